@@ rtl/bfha_pkg.sv @@
// ----------------------------------------------------------------------------
// bfha_pkg
// shared types and codes for the best-fit heap allocator
// ----------------------------------------------------------------------------
package bfha_pkg;

    // request codes
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_FREE     = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;
    localparam logic [1:0] MODE_RSVD     = 2'd3;

    // address class codes
    localparam logic [3:0] CLS_NULL       = 4'd0;
    localparam logic [3:0] CLS_INVALID    = 4'd1;
    localparam logic [3:0] CLS_FREE_SZ    = 4'd2;
    localparam logic [3:0] CLS_FREE_SZ_U  = 4'd3;
    localparam logic [3:0] CLS_FREE_NX    = 4'd4;
    localparam logic [3:0] CLS_FREE_NX_U  = 4'd5;
    localparam logic [3:0] CLS_FREE_DAT   = 4'd6;
    localparam logic [3:0] CLS_FREE_DAT_U = 4'd7;
    localparam logic [3:0] CLS_USED_SZ    = 4'd8;
    localparam logic [3:0] CLS_USED_SZ_U  = 4'd9;
    localparam logic [3:0] CLS_USED_DAT   = 4'd10;
    localparam logic [3:0] CLS_USED_DAT_U = 4'd11;

    // width of rounded request size and its search bound
    localparam int SZW = 18;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DISPATCH,
        S_A_START,
        S_A_FB,
        S_A_FS,
        S_A_END,
        S_G_RD,
        S_G_LINK,
        S_G_RDSZ,
        S_G_SZ,
        S_G_HDR,
        S_G_REM,
        S_P_RD,
        S_P_LINK,
        S_P_HEAD,
        S_C_START,
        S_C_LOOP,
        S_C_SZ,
        S_C_NX,
        S_B_START,
        S_B_LOOP,
        S_B_SZ,
        S_FAIL,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_DISPATCH,
        OP_A_START,
        OP_A_FB,
        OP_A_FS,
        OP_G_RD,
        OP_G_LINK,
        OP_G_RDSZ,
        OP_G_SZ,
        OP_G_HDR,
        OP_G_REM,
        OP_P_RD,
        OP_P_LINK,
        OP_P_HEAD,
        OP_C_START,
        OP_C_RDSZ,
        OP_C_SZ,
        OP_C_NX,
        OP_B_START,
        OP_B_RDSZ,
        OP_B_SZ,
        OP_FAIL,
        OP_LOAD
    } op_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       clr_last;
        logic       free_ok;
        logic       cls_trivial;
        logic       fb_zero;
        logic       walk_end;
        logic       best_none;
        logic       split;
        logic       n_lim;
        logic       cur_zero;
        logic       found;
        logic       blk_out;
        logic       chain_go;
        logic       out_busy;
    } status_t;

endpackage

@@ rtl/bfha_ram.sv @@
// ----------------------------------------------------------------------------
// bfha_ram
// single-port word store, registered read
// ----------------------------------------------------------------------------
module bfha_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/bfha_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfha_ctrl
// sequencer for allocate, free and classify walks
// ----------------------------------------------------------------------------
module bfha_ctrl
    import bfha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t st,
    output op_t     op
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:      if (st.clr_last) state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (st.mode)
                    MODE_ALLOC:    state_next = S_A_START;
                    MODE_FREE:     state_next = st.free_ok ? S_P_RD : S_DONE;
                    MODE_CLASSIFY: state_next = st.cls_trivial ? S_DONE : S_C_START;
                    default:       state_next = S_DONE;
                endcase
            end
            S_A_START:  state_next = S_A_FB;
            S_A_FB:     state_next = st.fb_zero ? S_A_END : S_A_FS;
            S_A_FS:     state_next = st.walk_end ? S_A_END : S_A_FB;
            S_A_END:    state_next = st.best_none ? S_FAIL : S_G_RD;
            S_G_RD:     state_next = S_G_LINK;
            S_G_LINK:   state_next = S_G_RDSZ;
            S_G_RDSZ:   state_next = S_G_SZ;
            S_G_SZ:     state_next = st.split ? S_G_HDR : S_DONE;
            S_G_HDR:    state_next = S_G_REM;
            S_G_REM:    state_next = S_P_RD;
            S_P_RD:     state_next = S_P_LINK;
            S_P_LINK:   state_next = S_P_HEAD;
            S_P_HEAD:   state_next = S_DONE;
            S_C_START:  state_next = S_C_LOOP;
            S_C_LOOP:   state_next = (st.n_lim || st.cur_zero) ? S_B_START : S_C_SZ;
            S_C_SZ:     state_next = st.found ? S_DONE : S_C_NX;
            S_C_NX:     state_next = S_C_LOOP;
            S_B_START:  state_next = S_B_LOOP;
            S_B_LOOP:   state_next = (st.n_lim || st.blk_out) ? S_DONE : S_B_SZ;
            S_B_SZ:     state_next = st.chain_go ? S_B_LOOP : S_DONE;
            S_FAIL:     state_next = S_DONE;
            S_DONE:     if (!st.out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op = OP_NONE;
        case (state_reg)
            S_CLR:      op = OP_CLEAR;
            S_IDLE:     op = in_valid ? OP_ACCEPT : OP_NONE;
            S_DISPATCH: op = OP_DISPATCH;
            S_A_START:  op = OP_A_START;
            S_A_FB:     op = OP_A_FB;
            S_A_FS:     op = OP_A_FS;
            S_A_END:    op = OP_NONE;
            S_G_RD:     op = OP_G_RD;
            S_G_LINK:   op = OP_G_LINK;
            S_G_RDSZ:   op = OP_G_RDSZ;
            S_G_SZ:     op = OP_G_SZ;
            S_G_HDR:    op = OP_G_HDR;
            S_G_REM:    op = OP_G_REM;
            S_P_RD:     op = OP_P_RD;
            S_P_LINK:   op = OP_P_LINK;
            S_P_HEAD:   op = OP_P_HEAD;
            S_C_START:  op = OP_C_START;
            S_C_LOOP:   op = OP_C_RDSZ;
            S_C_SZ:     op = OP_C_SZ;
            S_C_NX:     op = OP_C_NX;
            S_B_START:  op = OP_B_START;
            S_B_LOOP:   op = OP_B_RDSZ;
            S_B_SZ:     op = OP_B_SZ;
            S_FAIL:     op = OP_FAIL;
            S_DONE:     op = st.out_busy ? OP_NONE : OP_LOAD;
            default:    op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/bfha_dp.sv @@
// ----------------------------------------------------------------------------
// bfha_dp
// heap word store, walk registers and result register
// ----------------------------------------------------------------------------
module bfha_dp
    import bfha_pkg::*;
#(
    parameter int HEAP_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         op,
    output status_t     st,
    input  logic [1:0]  mode,
    input  logic [15:0] request_size,
    input  logic [15:0] request_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] granted_address,
    output logic [15:0] granted_size,
    output logic [3:0]  address_class,
    output logic        failed
);

    localparam int DW = $clog2(HEAP_BYTES) + 1;
    localparam int CW = DW + 2;
    localparam int HW = HEAP_BYTES / 4;
    localparam int IW = $clog2(HW);
    localparam int NW = $clog2(HW + 2);
    localparam logic [CW-1:0] WB     = CW'(4);
    localparam logic [CW-1:0] HB_C   = CW'(HEAP_BYTES);
    localparam logic [16:0]   HB_A   = 17'(HEAP_BYTES);
    localparam logic [NW-1:0] LIMIT  = NW'(HW + 1);
    localparam logic [IW-1:0] LAST_I = IW'(HW - 1);

    logic [1:0]     mode_reg;
    logic [15:0]    a_reg;
    logic [SZW-1:0] bs_reg, need_reg;
    logic [CW-1:0]  cur_reg, fb_reg, best_reg, best_prev_reg, push_reg;
    logic [DW-1:0]  best_sz_reg, fs2_reg;
    logic [NW-1:0]  n_reg;
    logic [IW-1:0]  clr_reg;
    logic           rd_ok_reg;
    logic [15:0]    gaddr_reg, gsize_reg;
    logic [3:0]     cls_reg;
    logic           fail_reg;
    logic           out_valid_reg;
    logic [15:0]    out_addr_reg, out_size_reg;
    logic [3:0]     out_cls_reg;
    logic           out_fail_reg;

    logic [DW-1:0]  ram_q, rdv, wdata, init_val;
    logic [CW-1:0]  rdv_w, acc, a_w, blk_sz;
    logic           acc_wr, in_rng, ram_we;
    logic [IW-1:0]  ram_addr;
    logic [16:0]    sz_ext;
    logic [SZW-1:0] bs_c, rdv_s;
    logic           fit, found_c, chain_go_c;
    logic [3:0]     free_cls, chain_cls;

    assign rdv   = rd_ok_reg ? ram_q : '0;
    assign rdv_w = CW'(rdv);
    assign rdv_s = SZW'(rdv);
    assign a_w   = CW'(a_reg);

    // rounding to whole words, zero becomes one word
    assign sz_ext = {1'b0, request_size};
    assign bs_c   = (request_size == 16'd0) ? SZW'(4)
                                            : SZW'((sz_ext + 17'd3) & ~17'd3);

    always_comb
    begin
        case (clr_reg)
            IW'(0):  init_val = DW'(4);
            IW'(1):  init_val = DW'(12);
            IW'(2):  init_val = DW'(HEAP_BYTES - 12);
            default: init_val = '0;
        endcase
    end

    // word access address and data per op
    always_comb
    begin
        acc    = '0;
        acc_wr = 1'b0;
        wdata  = '0;
        case (op)
            OP_A_START: acc = WB;
            OP_A_FB:    acc = rdv_w - WB;
            OP_A_FS:    acc = fb_reg;
            OP_G_RD:    acc = best_reg;
            OP_G_LINK:
            begin
                acc    = best_prev_reg;
                acc_wr = 1'b1;
                wdata  = rdv;
            end
            OP_G_RDSZ:  acc = best_reg - WB;
            OP_G_HDR:
            begin
                acc    = best_reg - WB;
                acc_wr = 1'b1;
                wdata  = DW'(bs_reg);
            end
            OP_G_REM:
            begin
                acc    = push_reg - WB;
                acc_wr = 1'b1;
                wdata  = DW'(fs2_reg - DW'(bs_reg) - DW'(4));
            end
            OP_P_RD:    acc = WB;
            OP_P_LINK:
            begin
                acc    = push_reg;
                acc_wr = 1'b1;
                wdata  = rdv;
            end
            OP_P_HEAD:
            begin
                acc    = WB;
                acc_wr = 1'b1;
                wdata  = DW'(push_reg);
            end
            OP_C_RDSZ:  acc = cur_reg - WB;
            OP_C_SZ:    acc = cur_reg;
            OP_B_RDSZ:  acc = cur_reg - WB;
            default:    acc = '0;
        endcase
    end

    assign in_rng   = (acc < HB_C);
    assign ram_we   = (op == OP_CLEAR) || (acc_wr && in_rng);
    assign ram_addr = (op == OP_CLEAR) ? clr_reg : acc[IW+1:2];

    bfha_ram #(
        .WIDTH (DW),
        .DEPTH (HW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata ((op == OP_CLEAR) ? init_val : wdata),
        .rdata (ram_q)
    );

    // search and classify decisions
    assign fit        = (need_reg <= rdv_s) && ((best_sz_reg == '0) || (rdv < best_sz_reg));
    assign found_c    = !((a_w < cur_reg - WB) || (cur_reg + rdv_w <= a_w));
    assign chain_go_c = (a_w < cur_reg - WB) || (cur_reg + rdv_w <= a_w);
    assign blk_sz     = cur_reg + rdv_w + WB;

    always_comb
    begin
        if (a_w == cur_reg - WB)      free_cls = CLS_FREE_SZ;
        else if (a_w < cur_reg)       free_cls = CLS_FREE_SZ_U;
        else if (a_w == cur_reg)      free_cls = CLS_FREE_NX;
        else if (a_w < cur_reg + WB)  free_cls = CLS_FREE_NX_U;
        else if (a_w == cur_reg + WB) free_cls = CLS_FREE_DAT;
        else                          free_cls = CLS_FREE_DAT_U;

        if (a_w == cur_reg - WB)      chain_cls = CLS_USED_SZ;
        else if (a_w < cur_reg)       chain_cls = CLS_USED_SZ_U;
        else if (a_w == cur_reg)      chain_cls = CLS_USED_DAT;
        else                          chain_cls = CLS_USED_DAT_U;
    end

    always_comb
    begin
        st             = '0;
        st.mode        = mode_reg;
        st.clr_last    = (clr_reg == LAST_I);
        st.free_ok     = (a_reg != 16'd0) && ({1'b0, a_reg} < HB_A);
        st.cls_trivial = (a_reg == 16'd0) || ({1'b0, a_reg} >= HB_A);
        st.fb_zero     = (rdv == '0);
        st.walk_end    = (NW'(n_reg + NW'(1)) == LIMIT);
        st.best_none   = (best_reg == '0);
        st.split       = (bs_reg < rdv_s);
        st.n_lim       = (n_reg == LIMIT);
        st.cur_zero    = (cur_reg == '0);
        st.found       = found_c;
        st.blk_out     = (cur_reg >= HB_C);
        st.chain_go    = chain_go_c;
        st.out_busy    = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= in_rng;
            if (op == OP_CLEAR)
            begin
                clr_reg <= IW'(clr_reg + IW'(1));
            end
            if (op == OP_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_ACCEPT:
            begin
                mode_reg  <= mode;
                a_reg     <= request_address;
                bs_reg    <= bs_c;
                need_reg  <= bs_c + SZW'(8);
                gaddr_reg <= '0;
                gsize_reg <= '0;
                cls_reg   <= CLS_NULL;
                fail_reg  <= 1'b0;
            end
            OP_DISPATCH:
            begin
                push_reg <= CW'(a_reg);
                if (mode_reg == MODE_CLASSIFY && st.cls_trivial)
                begin
                    cls_reg <= (a_reg == 16'd0) ? CLS_NULL : CLS_INVALID;
                end
            end
            OP_A_START:
            begin
                cur_reg     <= WB;
                n_reg       <= '0;
                best_reg    <= '0;
                best_sz_reg <= '0;
            end
            OP_A_FB: fb_reg <= rdv_w;
            OP_A_FS:
            begin
                if (fit)
                begin
                    best_prev_reg <= cur_reg;
                    best_reg      <= fb_reg;
                    best_sz_reg   <= rdv;
                end
                cur_reg <= fb_reg;
                n_reg   <= NW'(n_reg + NW'(1));
            end
            OP_G_SZ:
            begin
                fs2_reg   <= rdv;
                gaddr_reg <= 16'(best_reg);
                gsize_reg <= bs_reg[15:0];
            end
            OP_G_HDR: push_reg <= best_reg + CW'(bs_reg) + WB;
            OP_C_START, OP_B_START:
            begin
                cur_reg <= WB;
                n_reg   <= '0;
            end
            OP_C_SZ:  if (found_c) cls_reg <= free_cls;
            OP_C_NX:
            begin
                cur_reg <= rdv_w;
                n_reg   <= NW'(n_reg + NW'(1));
            end
            OP_B_RDSZ: cls_reg <= chain_cls;
            OP_B_SZ:
            begin
                cls_reg <= chain_cls;
                if (chain_go_c)
                begin
                    cur_reg <= blk_sz;
                    n_reg   <= NW'(n_reg + NW'(1));
                end
            end
            OP_FAIL: fail_reg <= 1'b1;
            OP_LOAD:
            begin
                out_addr_reg <= gaddr_reg;
                out_size_reg <= gsize_reg;
                out_cls_reg  <= cls_reg;
                out_fail_reg <= fail_reg;
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign granted_address = out_addr_reg;
    assign granted_size    = out_size_reg;
    assign address_class   = out_cls_reg;
    assign failed          = out_fail_reg;

endmodule

@@ rtl/best_fit_heap_allocator_top.sv @@
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top
// best-fit free-list heap allocator with address classifier
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. Block headers and free-list links
// sit in a single-port word store of HEAP_BYTES/4 words; every word access
// issues a registered read and then uses the data, so the cost is set by
// that one port. Allocate walks the whole free list, reading each free block's
// link and size, then unlinks the best fit and, when it is larger than
// needed, splits it and pushes the remainder. Free pushes the block onto the
// free list. Classify walks the free list and, when the address is not in a
// free block, the block chain. All walks stop after HEAP_BYTES/4+1 steps.
// After reset the store is initialized one word a cycle, so no request is
// taken before every word is written. A new request beat is taken while the
// previous result beat still waits at the output.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_top
    import bfha_pkg::*;
#(
    parameter int HEAP_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] request_size,
    input  logic [15:0] request_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] granted_address,
    output logic [15:0] granted_size,
    output logic [3:0]  address_class,
    output logic        failed
);

    status_t st;
    op_t     op;

    // sequencer
    bfha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .op       (op)
    );

    // store, walk registers and output beat register
    bfha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .st              (st),
        .mode            (mode),
        .request_size    (request_size),
        .request_address (request_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .granted_address (granted_address),
        .granted_size    (granted_size),
        .address_class   (address_class),
        .failed          (failed)
    );

    // a failed allocate grants nothing
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> (granted_address == 16'd0 && granted_size == 16'd0))
        else $error("failed beat carries a grant");

    // a classify result never carries a grant
    a_cls_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && address_class != CLS_NULL) |-> (granted_size == 16'd0 && !failed))
        else $error("classify beat carries a grant");

    // granted sizes are whole words
    a_grant_words: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted_size[1:0] == 2'd0))
        else $error("granted size not word multiple");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second request taken while busy");

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the best-fit heap allocator: a mirror of the heap
// predicts every result beat, random request and response idling, directed
// corners first, then allocate/free/classify traffic with random content
// ----------------------------------------------------------------------------
module tb
    import bfha_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP = 4096;
    localparam int HWORDS = HEAP / 4;
    localparam int WALK_MAX = HWORDS + 1;
    localparam int CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] size;
        logic [15:0] addr;
    } req_t;

    typedef struct packed {
        logic [15:0] gaddr;
        logic [15:0] gsize;
        logic [3:0]  cls;
        logic        fail;
    } rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  mode = MODE_ALLOC;
    logic [15:0] request_size = '0;
    logic [15:0] request_address = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] granted_address;
    logic [15:0] granted_size;
    logic [3:0]  address_class;
    logic        failed;

    best_fit_heap_allocator_top #(.HEAP_BYTES(HEAP)) i_dut (.*);

    always #2 clk = ~clk;

    // heap mirror, 32-bit words as the allocator sees them
    logic [31:0] heap_mirror[HWORDS];
    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    logic [15:0] live_blocks[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;      // long stretch with no idling on either side
    bit   hold_off = 1'b0;   // sender waits for the pipe to drain

    function automatic logic [31:0] rd(logic [31:0] a);
        return ((a >> 2) < HWORDS) ? heap_mirror[a >> 2] : 32'd0;
    endfunction

    function automatic void wr(logic [31:0] a, logic [31:0] v);
        if ((a >> 2) < HWORDS)
            heap_mirror[a >> 2] = v;
    endfunction

    function automatic void push_free(logic [31:0] a);
        wr(a, rd(4));
        wr(4, a);
    endfunction

    function automatic void heap_init();
        foreach (heap_mirror[i])
            heap_mirror[i] = '0;
        wr(0, 4);
        wr(4, 12);
        wr(8, HEAP - 12);
    endfunction

    // free block holding address a, 0 when none
    function automatic logic [31:0] free_block_of(logic [31:0] a);
        logic [31:0] cur;
        cur = 4;
        for (int n = 0; n < WALK_MAX; n++)
        begin
            if (cur == 0)
                return 0;
            if (!(a < cur - 4 || cur + rd(cur - 4) <= a))
                return cur;
            cur = rd(cur);
        end
        return 0;
    endfunction

    function automatic logic [3:0] region_of(logic [31:0] a);
        logic [31:0] fb;
        logic [31:0] blk;
        if (a == 0)
            return CLS_NULL;
        if (a >= HEAP)
            return CLS_INVALID;
        fb = free_block_of(a);
        if (fb != 0)
        begin
            if (a == fb - 4) return CLS_FREE_SZ;
            if (a < fb) return CLS_FREE_SZ_U;
            if (a == fb) return CLS_FREE_NX;
            if (a < fb + 4) return CLS_FREE_NX_U;
            if (a == fb + 4) return CLS_FREE_DAT;
            return CLS_FREE_DAT_U;
        end
        blk = 4;
        for (int n = 0; n < WALK_MAX; n++)
        begin
            if (!(blk < HEAP && (a < blk - 4 || blk + rd(blk - 4) <= a)))
                break;
            blk = blk + rd(blk - 4) + 4;
        end
        if (a == blk - 4) return CLS_USED_SZ;
        if (a < blk) return CLS_USED_SZ_U;
        if (a == blk) return CLS_USED_DAT;
        return CLS_USED_DAT_U;
    endfunction

    function automatic rsp_t heap_step(req_t r);
        rsp_t o;
        logic [31:0] bs, need, cur, best, best_sz, best_prev, fb, fs, rem;
        o = '0;
        if (r.mode == MODE_ALLOC)
        begin
            bs = (r.size == 0) ? 32'd4 : ((((32'(r.size) - 1) >> 2) + 1) << 2);
            need = bs + 8;
            cur = 4;
            best = 0;
            best_sz = 0;
            best_prev = 0;
            for (int n = 0; n < WALK_MAX; n++)
            begin
                fb = rd(cur);
                if (fb == 0)
                    break;
                fs = rd(fb - 4);
                if (need <= fs && (best_sz == 0 || fs < best_sz))
                begin
                    best_prev = cur;
                    best = fb;
                    best_sz = fs;
                end
                cur = fb;
            end
            if (best == 0)
                o.fail = 1'b1;
            else
            begin
                wr(best_prev, rd(best));
                fs = rd(best - 4);
                if (bs < fs)
                begin
                    rem = best + bs + 4;
                    wr(best - 4, bs);
                    wr(rem - 4, best + fs - rem);
                    push_free(rem);
                end
                o.gaddr = best[15:0];
                o.gsize = bs[15:0];
            end
        end
        else if (r.mode == MODE_FREE)
        begin
            if (r.addr != 0 && r.addr < HEAP)
                push_free(32'(r.addr));
        end
        else if (r.mode == MODE_CLASSIFY)
            o.cls = region_of(32'(r.addr));
        return o;
    endfunction

    // driver: nonblocking at the edge, payload held while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 && !hold_off
                    && (quiet || $urandom_range(99) >= 23))
                begin
                    req_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    mode <= r.mode;
                    request_size <= r.size;
                    request_address <= r.addr;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 23);
        end
    end

    // request monitor: predict at acceptance, in beat order
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_rsps.push_back(heap_step({mode, request_size, request_address}));
    end

    // result monitor: compare against the oldest prediction
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            rsp_t got;
            rsp_t exp;
            got = {granted_address, granted_size, address_class, failed};
            if (expected_rsps.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result beat %h", got);
            end
            else
            begin
                exp = expected_rsps.pop_front();
                if (got !== exp)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: addr %h/%h size %h/%h class %0d/%0d fail %b/%b",
                                 exp.gaddr, granted_address, exp.gsize, granted_size,
                                 exp.cls, address_class, exp.fail, failed);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void add(logic [1:0] m, logic [15:0] s, logic [15:0] a);
        pending_reqs.push_back({m, s, a});
    endfunction

    // address near the start of a live block, mostly well formed
    function automatic logic [15:0] pick_addr();
        if (live_blocks.size() > 0 && $urandom_range(3) != 0)
            return live_blocks[$urandom_range(live_blocks.size() - 1)]
                   + 16'($urandom_range(8)) - 16'd4;
        return ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(HEAP + 8));
    endfunction

    // model-side shadow used only to steer random frees toward live blocks
    function automatic void track(req_t r);
        int k;
        if (r.mode == MODE_FREE && live_blocks.size() > 0 && $urandom_range(9) != 0)
        begin
            k = $urandom_range(live_blocks.size() - 1);
            live_blocks.delete(k);
        end
    endfunction

    initial
    begin
        req_t r;
        logic [15:0] sz;
        int  mlt;
        heap_init();
        // directed: corners of every field and every request kind
        add(MODE_CLASSIFY, 16'h0000, 16'h0000);
        add(MODE_CLASSIFY, 16'hffff, 16'hffff);
        add(MODE_CLASSIFY, 16'h0000, 16'(HEAP));
        add(MODE_CLASSIFY, 16'h0000, 16'd8);
        add(MODE_CLASSIFY, 16'h0000, 16'd13);
        add(MODE_ALLOC, 16'h0000, 16'hffff);
        add(MODE_ALLOC, 16'h0001, 16'h0000);
        add(MODE_ALLOC, 16'd5, 16'h0000);
        add(MODE_ALLOC, 16'hffff, 16'h0000);
        add(MODE_ALLOC, 16'd4060, 16'h0000);
        add(MODE_RSVD, 16'hffff, 16'hffff);
        add(MODE_CLASSIFY, 16'h0000, 16'd16);
        add(MODE_CLASSIFY, 16'h0000, 16'd19);
        add(MODE_FREE, 16'h0000, 16'h0000);
        add(MODE_FREE, 16'h0000, 16'hffff);
        add(MODE_FREE, 16'h0000, 16'd16);
        add(MODE_FREE, 16'h0000, 16'd16);
        add(MODE_CLASSIFY, 16'h0000, 16'd20);
        add(MODE_ALLOC, 16'd8, 16'h0000);
        add(MODE_FREE, 16'h0000, 16'd23);
        add(MODE_CLASSIFY, 16'h0000, 16'd22);
        add(MODE_CLASSIFY, 16'h0000, 16'd4095);
        add(MODE_ALLOC, 16'd3000, 16'h0000);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // let the directed part and its double free drain
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (4000) @(posedge clk);

        // random traffic: alloc most often, mostly with small sizes, frees of live
        // blocks, classifies near block edges, a little noise
        for (int i = 0; i < 630; i++)
        begin
            mlt = $urandom_range(99);
            if (mlt < 40)
            begin
                sz = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(200));
                r = {MODE_ALLOC, sz, 16'($urandom)};
            end
            else if (mlt < 65)
                r = {MODE_FREE, 16'($urandom), pick_addr()};
            else if (mlt < 97)
                r = {MODE_CLASSIFY, 16'($urandom), pick_addr()};
            else
                r = {MODE_RSVD, 16'($urandom), 16'($urandom)};
            track(r);
            wait (pending_reqs.size() < 4);
            pending_reqs.push_back(r);
            if (r.mode == MODE_ALLOC)
            begin
                // live-block list follows the actual predictions lazily
                wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
                live_blocks.push_back(16'(rd(4)) == 0 ? 16'd16 : 16'(rd(4)));
            end
            if (i == 100)
                quiet = 1'b1;
            if (i == 250)
                quiet = 1'b0;
            if (i == 400)
            begin
                // sender holds off until every result is back
                hold_off = 1'b1;
                wait (expected_rsps.size() == 0);
                hold_off = 1'b0;
            end
        end

        wait (pending_reqs.size() == 0 && !in_valid);
        wait (expected_rsps.size() == 0);
        repeat (4000) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
